FILE: sv/rabc_pkg.sv
// Package for rank_assign_by_count: widths and capacity shared by the interfaces and the RTL.
`timescale 1ns / 1ps

package rabc_pkg;

  // Storage capacity of one set (legal range 2..64)
  localparam int MAX_ITEMS = 64;

  // Word field widths
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;

  // Store index and fill count widths
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

endpackage

FILE: sv/rabc_if.sv
// Valid/ready channel interfaces for the value input and the rank output.
`timescale 1ns / 1ps

interface rabc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rabc_pkg::VALUE_W-1:0] value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface rabc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rabc_pkg::RANK_W-1:0] rank;
  logic                        overflow;
  logic                        final_res;

  modport source (output valid, output rank, output overflow, output final_res, input ready);
  modport sink   (input valid, input rank, input overflow, input final_res, output ready);
endinterface

FILE: sv/rank_assign_by_count.sv
// Top level: rank of each value in a set, counted with one shared comparator over a value store.
//
//  channel | dir | word fields                   | handshake
//  item    | in  | value[31:0] signed, last      | valid/ready
//  res     | out | rank[5:0], overflow, final_res | valid/ready
//
//  Input words are taken one per cycle while a set is being collected.
//  After the last word, each of the n stored values takes a store read for
//  its key, a latch, then a compare against every stored value through the
//  single comparator and the store's one read port, held until its rank is taken.
//  Input is not ready from the last word until the final rank is taken.
//  Synchronous active-high reset empties the set; no clearing pass.
`timescale 1ns / 1ps

module rank_assign_by_count (
  input  logic              clk,
  input  logic              rst,
  rabc_in_if.sink           item,
  rabc_out_if.source        res
);

  typedef enum logic [4:0] {
    S_COLLECT = 5'b00001,
    S_READ    = 5'b00010,
    S_LATCH   = 5'b00100,
    S_SCAN    = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t state;

  // Control registers
  logic [rabc_pkg::CNT_W-1:0]  item_count;
  logic                        overflow_seen;
  logic [rabc_pkg::IDX_W-1:0]  i;
  logic [rabc_pkg::CNT_W-1:0]  j;
  logic [rabc_pkg::RANK_W-1:0] cnt;

  // Payload registers
  logic signed [rabc_pkg::VALUE_W-1:0] key;
  logic [rabc_pkg::RANK_W-1:0]         res_rank;
  logic                                res_final;

  // Value store
  logic signed [rabc_pkg::VALUE_W-1:0] mem [rabc_pkg::MAX_ITEMS];
  logic signed [rabc_pkg::VALUE_W-1:0] rd_data;
  logic [rabc_pkg::IDX_W-1:0]          rd_addr;

  logic                        in_fire;
  logic                        out_fire;
  logic                        has_room;
  logic                        lt;
  logic [rabc_pkg::RANK_W-1:0] cnt_sum;
  logic                        is_final;

  assign in_fire  = item.valid && item.ready;
  assign out_fire = res.valid && res.ready;
  assign has_room = item_count < rabc_pkg::CNT_W'(rabc_pkg::MAX_ITEMS);

  // Shared comparator and counter
  assign lt       = rd_data < key;
  assign cnt_sum  = cnt + rabc_pkg::RANK_W'(lt);
  assign is_final = (rabc_pkg::CNT_W'(i) + rabc_pkg::CNT_W'(1)) == item_count;

  // Handshake outputs
  assign item.ready    = (state == S_COLLECT);
  assign res.valid     = (state == S_EMIT);
  assign res.rank      = res_rank;
  assign res.overflow  = overflow_seen;
  assign res.final_res = res_final;

  // Store read address
  always_comb begin
    case (state)
      S_READ:  rd_addr = i;
      S_SCAN:  rd_addr = j[rabc_pkg::IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (in_fire && has_room) begin
      mem[item_count[rabc_pkg::IDX_W-1:0]] <= item.value;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_COLLECT;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      cnt           <= '0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (in_fire) begin
            if (has_room) begin
              item_count <= item_count + rabc_pkg::CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (item.last) begin
              i     <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          // key arrives now; address 0 is in flight
          j     <= rabc_pkg::CNT_W'(1);
          cnt   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // rd_data holds entry j-1
          cnt <= cnt_sum;
          if (j == item_count) begin
            state <= S_EMIT;
          end else begin
            j <= j + rabc_pkg::CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (out_fire) begin
            if (res_final) begin
              item_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= S_COLLECT;
            end else begin
              i     <= i + rabc_pkg::IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  // Key and result word
  always_ff @(posedge clk) begin
    if (state == S_LATCH) begin
      key <= rd_data;
    end
    if (state == S_SCAN && j == item_count) begin
      res_rank  <= cnt_sum;
      res_final <= is_final;
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= rabc_pkg::CNT_W'(rabc_pkg::MAX_ITEMS))
    else $error("store count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> item_count != '0)
    else $error("result with empty store");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (rabc_pkg::CNT_W'(cnt) < j && j <= item_count))
    else $error("scan count or index out of range");

  a_close_set: assert property (@(posedge clk) disable iff (rst)
    (out_fire && res.final_res) |=> (item_count == '0 && !overflow_seen && item.ready))
    else $error("set not closed after final rank");

endmodule

FILE: tb/sv/rank_assign_by_count_tb.sv
// Testbench for rank_assign_by_count: directed and random value sets, ranks checked in order.
`timescale 1ns / 1ps

module rank_assign_by_count_tb;
  import rabc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int ITEM_TARGET  = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 2 * MAX_ITEMS + 40;
  localparam int NO_PIN       = -1;
  localparam int DIR_ROWS_N   = 14;

  // One expected rank word
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              overflow;
    logic              final_res;
  } rank_word_t;

  // Directed row: value, last flag, and a hand-typed rank where obvious
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               pinned;
    logic [RANK_W-1:0]  pin_rank;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // lone value
    '{32'h00000000, 1'b1, 1'b1, 6'd0},
    // extremes of the signed range
    '{32'h80000000, 1'b0, 1'b1, 6'd0},
    '{32'h7FFFFFFF, 1'b0, 1'b1, 6'd3},
    '{32'h00000000, 1'b0, 1'b1, 6'd2},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 6'd1},
    // equal values share a rank
    '{32'h00000005, 1'b0, 1'b1, 6'd0},
    '{32'h00000005, 1'b0, 1'b1, 6'd0},
    '{32'h00000005, 1'b1, 1'b1, 6'd0},
    // mixed signs with a repeat
    '{32'h00000064, 1'b0, 1'b0, 6'd0},
    '{32'hFFFFFF9C, 1'b0, 1'b0, 6'd0},
    '{32'h00000064, 1'b0, 1'b0, 6'd0},
    '{32'h00000003, 1'b1, 1'b0, 6'd0},
    // alternating bit patterns
    '{32'hAAAAAAAA, 1'b0, 1'b1, 6'd0},
    '{32'h55555555, 1'b1, 1'b1, 6'd1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rabc_in_if  item_ch ();
  rabc_out_if res_ch ();

  rank_assign_by_count DUT (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .res  (res_ch)
  );

  // Predictor state for the open set
  logic signed [VALUE_W-1:0] open_vals[$];
  int                        open_pins[$];
  bit                        open_ovf = 1'b0;
  rank_word_t                ranks_due[$];

  int  err_cnt        = 0;
  int  ranks_taken    = 0;
  int  items_sent     = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  int  cycle_cnt      = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Store one accepted word; on last, work out the rank of every stored value
  function automatic void rank_predict(logic signed [VALUE_W-1:0] v, bit l, int pin);
    int         cnt;
    rank_word_t w;
    if (open_vals.size() < MAX_ITEMS) begin
      open_vals.push_back(v);
      open_pins.push_back(pin);
    end else begin
      open_ovf = 1'b1;
    end
    if (!l) return;
    foreach (open_vals[i]) begin
      cnt = 0;
      foreach (open_vals[j]) begin
        if (open_vals[j] < open_vals[i]) cnt++;
      end
      w.rank      = (open_pins[i] == NO_PIN) ? RANK_W'(cnt) : RANK_W'(open_pins[i]);
      w.overflow  = open_ovf;
      w.final_res = (i == open_vals.size() - 1);
      ranks_due.push_back(w);
    end
    open_vals.delete();
    open_pins.delete();
    open_ovf = 1'b0;
  endfunction

  // Mix of full-range, clustered (repeats likely) and extreme values
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 15)) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh80000000;
          1:       return 32'sh7FFFFFFF;
          2:       return -1;
          default: return 0;
        endcase
      end
      default:    return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // Offer one word, with random idle gaps ahead of it
  task automatic send_word(logic signed [VALUE_W-1:0] v, bit l, int pin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.last  <= l;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    rank_predict(v, l, pin);
    items_sent++;
  endtask

  task automatic send_random_set(int len);
    for (int k = 0; k < len; k++) send_word(pick_value(), k == len - 1, NO_PIN);
  endtask

  // Stimulus: directed table, then random sets over several idling phases
  initial begin
    int set_no;
    int len;
    int r;
    set_no        = 0;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    item_ch.last  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < DIR_ROWS_N; d++) begin
      send_word(DIR_ROWS[d].value, DIR_ROWS[d].last,
                DIR_ROWS[d].pinned ? int'(DIR_ROWS[d].pin_rank) : NO_PIN);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      while (items_sent < ITEM_TARGET * (p + 1) / 4) begin
        // first a full set, then one that overflows and drops its last three words
        if (set_no == 0) begin
          len = MAX_ITEMS;
        end else if (set_no == 1) begin
          len = MAX_ITEMS + 3;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55) len = $urandom_range(1, 6);
          else if (r < 80) len = $urandom_range(7, 20);
          else if (r < 92) len = $urandom_range(21, MAX_ITEMS - 1);
          else if (r < 96) len = MAX_ITEMS;
          else len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
        end
        send_random_set(len);
        set_no++;
      end
    end
    item_ch.valid <= 1'b0;

    while (ranks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: check taken words, drive ready with random stalls and one long hold
  always @(posedge clk) begin
    rank_word_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        ranks_taken++;
        if (ranks_due.size() == 0) begin
          $error("rank word with none pending: rank %0d", res_ch.rank);
          err_cnt++;
        end else begin
          want = ranks_due.pop_front();
          if (res_ch.rank !== want.rank) begin
            $error("rank mismatch: expected %0d, got %0d", want.rank, res_ch.rank);
            err_cnt++;
          end
          if (res_ch.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, got %0b", want.overflow, res_ch.overflow);
            err_cnt++;
          end
          if (res_ch.final_res !== want.final_res) begin
            $error("final_res mismatch: expected %0b, got %0b",
                   want.final_res, res_ch.final_res);
            err_cnt++;
          end
        end
      end
      // long hold-off so the input side backs up
      if (!hold_done && ranks_taken >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
